>>> rtl/icsu_pkg.sv
`default_nettype none
package icsu_pkg;

	localparam int MAX_PIXELS_DEF    = 256;
	localparam int PALETTE_DEPTH_DEF = 256;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_LINE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT      = 2'd2;

	localparam logic CMD_DATA    = 1'b0;
	localparam logic CMD_PALETTE = 1'b1;

	localparam logic [8:0]  PPL_RESET        = 9'd256;
	localparam logic [15:0] LINE_COUNT_RESET = 16'd1;
	localparam logic [3:0]  NIBBLE_MASK      = 4'hF;

	typedef enum logic [1:0] {
		MODE_1BPP,
		MODE_4BPP,
		MODE_8BPP,
		MODE_TRUECOLOR
	} mode_t;

	typedef struct packed {
		mode_t       image_mode;
		logic [8:0]  pixels_per_line;
		logic [15:0] line_count;
	} cfg_t;

	// one pixel lookup request from the sequencer
	typedef struct packed {
		logic        valid;
		logic [7:0]  pal_idx;
		logic        direct;
		logic [23:0] rgb;
		logic [7:0]  pixel_index;
		logic [15:0] scan_line;
		logic        line_end;
		logic        run_last;
	} pix_req_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  idx;
		logic [23:0] rgb;
	} pal_wr_t;

endpackage
`default_nettype wire

>>> rtl/indexed_color_scanline_unpacker_unit.sv
// a data byte passes the sequencer's byte register, read stage and output register
// throughput: up to one pixel per cycle when not stalled at the output, set by the single
//   palette read port; pixels per byte: 1bpp 8 (fewer at line end), 4bpp 2, 8bpp 1, truecolor 1/3
// reset: counters, byte phase, valid flags and config go to defaults at once; palette is
//   undefined until written, no clearing pass
`default_nettype none
module indexed_color_scanline_unpacker_unit #(
	parameter int MAX_PIXELS    = icsu_pkg::MAX_PIXELS_DEF,
	parameter int PALETTE_DEPTH = icsu_pkg::PALETTE_DEPTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// data_byte, pal_index, pal_red, pal_green, pal_blue
	input  wire  [icsu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// cmd
	input  wire                               s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// pixel_index, scan_line, red, green, blue
	output logic [icsu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// line_end
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [icsu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [icsu_pkg::CFG_DATA_W-1:0]   cfg_data
);

	icsu_pkg::cfg_t     cfg_q;
	icsu_pkg::pix_req_t req;
	icsu_pkg::pal_wr_t  wr;
	icsu_pkg::pix_req_t req_s1;
	logic               valid_s1;
	logic [23:0]        rd_data;
	logic [23:0]        color_s1;
	logic               adv;
	logic               out_valid_q;
	logic [icsu_pkg::OUT_DATA_W-1:0] out_data_q;
	logic               out_end_q;
	logic               out_last_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_mode <= icsu_pkg::MODE_1BPP;
			cfg_q.pixels_per_line <= icsu_pkg::PPL_RESET;
			cfg_q.line_count <= icsu_pkg::LINE_COUNT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				icsu_pkg::REG_IMAGE_MODE: cfg_q.image_mode <= icsu_pkg::mode_t'(cfg_data[1:0]);
				icsu_pkg::REG_PIXELS_PER_LINE: cfg_q.pixels_per_line <= cfg_data[8:0];
				icsu_pkg::REG_LINE_COUNT: cfg_q.line_count <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv = !out_valid_q || m_axis_tready;

	icsu_sequencer #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.cfg(cfg_q),
		.adv(adv),
		.req(req),
		.wr(wr)
	);

	icsu_palette_ram #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_ram (
		.clk(clk),
		.rd_en(adv),
		.rd_idx(req.pal_idx),
		.rd_data(rd_data),
		.wr(wr)
	);

	// read stage
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
			out_valid_q <= valid_s1;
		end
	end

	assign color_s1 = req_s1.direct ? req_s1.rgb : rd_data;

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {color_s1[7:0], color_s1[15:8], color_s1[23:16],
				req_s1.scan_line, req_s1.pixel_index};
			out_end_q <= req_s1.line_end;
			out_last_q <= req_s1.run_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_end_q;
	assign m_axis_tlast = out_last_q;

`ifndef NO_ASSERTIONS
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("line end pixel not marked last of its byte");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
		else $error("pixel run broken before its last pixel");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.en && req.valid))
		else $error("palette write and pixel lookup issued together");
`endif

endmodule
`default_nettype wire

>>> rtl/icsu_palette_ram.sv
`default_nettype none
module icsu_palette_ram #(
	parameter int PALETTE_DEPTH = icsu_pkg::PALETTE_DEPTH_DEF
) (
	input  wire                    clk,
	input  wire                    rd_en,
	input  wire  [7:0]             rd_idx,
	output logic [23:0]            rd_data,
	input  wire  icsu_pkg::pal_wr_t wr
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [23:0] mem [PALETTE_DEPTH];
	logic [23:0] rd_raw_q;
	logic        rd_oob_q;
	logic        wr_ok;
	logic        rd_ok;

	assign wr_ok = {1'b0, wr.idx} < 9'(PALETTE_DEPTH);
	assign rd_ok = {1'b0, rd_idx} < 9'(PALETTE_DEPTH);

	always_ff @(posedge clk) begin
		if (wr.en && wr_ok) begin
			mem[wr.idx[AW-1:0]] <= wr.rgb;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_idx[AW-1:0]];
			rd_oob_q <= !rd_ok;
		end
	end

	// entries past the depth read as black
	assign rd_data = rd_oob_q ? 24'd0 : rd_raw_q;

endmodule
`default_nettype wire

>>> rtl/icsu_sequencer.sv
`default_nettype none
module icsu_sequencer #(
	parameter int MAX_PIXELS = icsu_pkg::MAX_PIXELS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [icsu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  wire                              s_axis_tuser,
	input  wire  icsu_pkg::cfg_t             cfg,
	input  wire                              adv,
	output icsu_pkg::pix_req_t               req,
	output icsu_pkg::pal_wr_t                wr
);

	localparam int PW = $clog2(MAX_PIXELS);
	localparam int CW = (PW + 1 > 10) ? PW + 1 : 10;

	logic                            cur_valid_q;
	logic                            cur_cmd_q;
	logic [icsu_pkg::IN_DATA_W-1:0]  cur_data_q;
	logic [2:0]                      slot_q;
	logic [PW-1:0]                   pix_q;
	logic [15:0]                     line_q;
	logic [1:0]                      phase_q;
	logic [7:0]                      red_q;
	logic [7:0]                      green_q;

	logic [7:0]  b;
	logic        emit;
	logic        done;
	logic        step;
	logic        accept;
	logic        line_end;
	logic [7:0]  idx;
	logic        direct;
	logic [23:0] rgb;
	logic [CW-1:0] ppl_w;
	logic [CW-1:0] ppl_eff;
	logic [CW-1:0] pix_w;
	logic [16:0]   lc_inc;
	logic [15:0]   lc_next;

	assign b = cur_data_q[7:0];

	always_comb begin
		ppl_w = CW'(cfg.pixels_per_line);
		ppl_eff = ppl_w;
		if (ppl_w == '0) begin
			ppl_eff = CW'(1);
		end else if (ppl_w > CW'(MAX_PIXELS)) begin
			ppl_eff = CW'(MAX_PIXELS);
		end
		pix_w = CW'(pix_q);
		line_end = (pix_w + CW'(1)) >= ppl_eff;
		lc_inc = {1'b0, line_q} + 17'd1;
		lc_next = (lc_inc >= {1'b0, cfg.line_count}) ? 16'd0 : lc_inc[15:0];
	end

	always_comb begin
		emit = 1'b0;
		done = 1'b1;
		idx = 8'd0;
		direct = 1'b0;
		rgb = {red_q, green_q, b};
		if (cur_cmd_q == icsu_pkg::CMD_DATA) begin
			case (cfg.image_mode)
				icsu_pkg::MODE_1BPP: begin
					emit = 1'b1;
					idx = {7'd0, b[slot_q]};
					done = (slot_q == 3'd7) || line_end;
				end
				icsu_pkg::MODE_4BPP: begin
					emit = 1'b1;
					idx = slot_q[0] ? {4'd0, b[3:0] & icsu_pkg::NIBBLE_MASK} : {4'd0, b[7:4]};
					done = slot_q[0] || line_end;
				end
				icsu_pkg::MODE_8BPP: begin
					emit = 1'b1;
					idx = b;
				end
				icsu_pkg::MODE_TRUECOLOR: begin
					emit = (phase_q == 2'd2);
					direct = 1'b1;
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	assign step = cur_valid_q && adv;
	assign s_axis_tready = !cur_valid_q || (step && done);
	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		req.valid = step && emit;
		req.pal_idx = idx;
		req.direct = direct;
		req.rgb = rgb;
		req.pixel_index = pix_w[7:0];
		req.scan_line = line_q;
		req.line_end = line_end;
		req.run_last = done;
		wr.en = step && (cur_cmd_q == icsu_pkg::CMD_PALETTE);
		wr.idx = cur_data_q[15:8];
		wr.rgb = {cur_data_q[23:16], cur_data_q[31:24], cur_data_q[39:32]};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_data_q <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_cmd_q <= icsu_pkg::CMD_DATA;
			slot_q <= 3'd0;
			pix_q <= '0;
			line_q <= 16'd0;
			phase_q <= 2'd0;
			red_q <= 8'd0;
			green_q <= 8'd0;
		end else begin
			if (accept) begin
				cur_valid_q <= 1'b1;
				cur_cmd_q <= s_axis_tuser;
				slot_q <= 3'd0;
			end else if (step && done) begin
				cur_valid_q <= 1'b0;
			end
			if (step && !done) begin
				slot_q <= slot_q + 3'd1;
			end
			if (step && emit) begin
				if (line_end) begin
					pix_q <= '0;
					line_q <= lc_next;
				end else begin
					pix_q <= pix_q + PW'(1);
				end
			end
			// truecolor byte gathering
			if (step && cur_cmd_q == icsu_pkg::CMD_DATA &&
				cfg.image_mode == icsu_pkg::MODE_TRUECOLOR) begin
				case (phase_q)
					2'd1: begin
						green_q <= b;
						phase_q <= 2'd2;
					end
					2'd2: begin
						phase_q <= 2'd0;
					end
					default: begin
						red_q <= b;
						phase_q <= 2'd1;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire
